// ===== rtl/pfc_pkg.sv =====
// Package for the Playfair digraph cipher: letter codes, ASCII constants,
// register indexes and the 5x5 square lookup functions.
// No dependencies.
package pfc_pkg;

  localparam int CodeW   = 5;
  localparam int DigitW  = 3;
  localparam int LetterW = 7;
  localparam int SqCells = 25;
  localparam int SqW     = SqCells * CodeW;
  localparam int CfgW    = 45;
  localparam int SqHighW = 35;

  typedef logic [CodeW-1:0]   code_t;
  typedef logic [DigitW-1:0]  digit_t;
  typedef logic [LetterW-1:0] letter_t;
  typedef logic [SqW-1:0]     square_t;

  typedef struct packed {
    digit_t group;
    digit_t slot;
  } grid_pos_t;

  typedef enum logic [1:0] {
    REG_SQUARE_LOW  = 2'd0,
    REG_SQUARE_MID  = 2'd1,
    REG_SQUARE_HIGH = 2'd2,
    REG_CIPHER_MODE = 2'd3
  } reg_idx_t;

  localparam code_t CODE_I = 5'd8;
  localparam code_t CODE_J = 5'd9;
  localparam code_t CODE_Q = 5'd16;
  localparam code_t CODE_X = 5'd23;
  localparam code_t CODE_Z = 5'd25;

  localparam logic [7:0] ASCII_UC_A  = 8'h41;
  localparam logic [7:0] ASCII_UC_Z  = 8'h5A;
  localparam logic [7:0] ASCII_LC_A  = 8'h61;
  localparam logic [7:0] ASCII_LC_Z  = 8'h7A;
  localparam logic [7:0] CASE_OFFSET = 8'h20;
  localparam letter_t    LETTER_A    = 7'h41;
  localparam letter_t    LETTER_MAX  = 7'h60;

  // Lowest position holding the code; position 0 when absent.
  function automatic grid_pos_t sq_find(square_t sq, code_t code);
    grid_pos_t pos;
    pos = '0;
    for (int i = SqCells - 1; i >= 0; i--) begin
      if (sq[i*CodeW +: CodeW] == code) begin
        pos.group = DigitW'(i / 5);
        pos.slot  = DigitW'(i % 5);
      end
    end
    return pos;
  endfunction

  function automatic code_t sq_at(square_t sq, grid_pos_t pos);
    code_t r;
    r = '0;
    for (int i = 0; i < SqCells; i++) begin
      if (pos.group == DigitW'(i / 5) && pos.slot == DigitW'(i % 5))
        r = sq[i*CodeW +: CodeW];
    end
    return r;
  endfunction

  // Step one place round a row or column, wrapping modulo 5.
  function automatic digit_t step5(digit_t v, logic dec);
    digit_t r;
    if (dec)
      r = (v == 3'd0) ? 3'd4 : v - 3'd1;
    else
      r = (v == 3'd4) ? 3'd0 : v + 3'd1;
    return r;
  endfunction

  function automatic letter_t to_ascii(code_t code);
    return LETTER_A + LetterW'(code);
  endfunction

endpackage

// ===== rtl/playfair_digraph_cipher_top.sv =====
// Top level of the Playfair digraph cipher: letter folding, filler and pad
// insertion, pairing, and the 5x5 square mapping. Uses pfc_pkg.
//
// A byte is accepted and its digraphs (none, one or two) pass through the job
// register and then the pair buffer to the output, one letter per cycle while
// the output is not stalled. A byte that releases two pairs holds the input
// until both pairs have entered the single pair buffer in front of the output,
// which drives one letter per cycle when not stalled. Input and output overlap,
// so streams of letters run at one byte per cycle when the output never stalls;
// each filler or pad letter adds a letter to the output and slows the stream.
// The square and mode may be written only while the block is idle. There is
// no start-up clearing pass.
module playfair_digraph_cipher_top
  import pfc_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_we,
  input  logic [1:0]      cfg_addr,
  input  logic [CfgW-1:0] cfg_wdata,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  logic [7:0]      in_tdata,   // [7:0] text_byte
  input  logic            in_tlast,   // message_end
  output logic            out_tvalid,
  input  logic            out_tready,
  output logic [7:0]      out_tdata,  // [6:0] cipher_letter, [7] zero
  output logic            out_tlast,  // run_last
  output logic            out_tuser   // [0] message_done
);

  // configuration
  logic [CfgW-1:0]    sq_low_r, sq_mid_r;
  logic [SqHighW-1:0] sq_high_r;
  logic               mode_r;
  square_t            square;

  // pairing state
  code_t held_letter_r, held_letter_nxt;
  logic  held_valid_r, held_valid_nxt;
  code_t prev_letter_r, prev_letter_nxt;
  logic  prev_valid_r, prev_valid_nxt;

  // job register: raw digraphs released by one byte
  logic  job_valid_r, job_two_r, job_idx_r, job_end_r;
  code_t job_a_r [2];
  code_t job_b_r [2];

  // pair buffer feeding the output
  logic    pb_valid_r, pb_sel_r, pb_last_r, pb_done_r;
  letter_t pb_a_r, pb_b_r;

  // front-end decode
  logic [7:0] byte_up;
  logic       is_letter, prev_hit;
  code_t      letter_c, filler_c;
  logic       h;
  code_t      hl;
  logic [1:0] np;
  code_t      pair_a [2];
  code_t      pair_b [2];

  // mapping
  code_t     cur_a, cur_b;
  grid_pos_t pos_a, pos_b, new_a, new_b;
  letter_t   map_a, map_b;

  logic in_fire, out_fire, pb_free, move, job_last_pair;

  assign square = {sq_high_r, sq_mid_r, sq_low_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_low_r  <= '0;
      sq_mid_r  <= '0;
      sq_high_r <= '0;
      mode_r    <= 1'b0;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_addr))
        REG_SQUARE_LOW:  sq_low_r  <= cfg_wdata;
        REG_SQUARE_MID:  sq_mid_r  <= cfg_wdata;
        REG_SQUARE_HIGH: sq_high_r <= cfg_wdata[SqHighW-1:0];
        REG_CIPHER_MODE: mode_r    <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Fold case, map J to I, then walk the up-to-three pushes of this byte
  // (filler, letter, Z pad) through the held letter.
  always_comb begin
    byte_up   = (in_tdata >= ASCII_LC_A && in_tdata <= ASCII_LC_Z) ?
                in_tdata - CASE_OFFSET : in_tdata;
    is_letter = byte_up >= ASCII_UC_A && byte_up <= ASCII_UC_Z;
    letter_c  = CodeW'(byte_up - ASCII_UC_A);
    if (letter_c == CODE_J)
      letter_c = CODE_I;
    filler_c  = (letter_c == CODE_X) ? CODE_Q : CODE_X;
    prev_hit  = is_letter && prev_valid_r && prev_letter_r == letter_c;

    h         = held_valid_r;
    hl        = held_letter_r;
    np        = '0;
    pair_a[0] = '0;
    pair_a[1] = '0;
    pair_b[0] = '0;
    pair_b[1] = '0;

    if (prev_hit) begin
      if (h) begin
        pair_a[np[0]] = hl;
        pair_b[np[0]] = filler_c;
        np = np + 2'd1;
        h  = 1'b0;
      end else begin
        hl = filler_c;
        h  = 1'b1;
      end
    end
    if (is_letter) begin
      if (h) begin
        pair_a[np[0]] = hl;
        pair_b[np[0]] = letter_c;
        np = np + 2'd1;
        h  = 1'b0;
      end else begin
        hl = letter_c;
        h  = 1'b1;
      end
    end
    if (in_tlast && h) begin
      pair_a[np[0]] = hl;
      pair_b[np[0]] = CODE_Z;
      np = np + 2'd1;
      h  = 1'b0;
    end

    held_letter_nxt = hl;
    held_valid_nxt  = h && !in_tlast;
    prev_letter_nxt = is_letter ? letter_c : prev_letter_r;
    prev_valid_nxt  = (is_letter || prev_valid_r) && !in_tlast;
  end

  // Square mapping of the job's current digraph
  always_comb begin
    cur_a = job_idx_r ? job_a_r[1] : job_a_r[0];
    cur_b = job_idx_r ? job_b_r[1] : job_b_r[0];
    pos_a = sq_find(square, cur_a);
    pos_b = sq_find(square, cur_b);
    if (pos_a.group == pos_b.group) begin
      new_a = '{group: pos_a.group, slot: step5(pos_a.slot, mode_r)};
      new_b = '{group: pos_b.group, slot: step5(pos_b.slot, mode_r)};
    end else if (pos_a.slot == pos_b.slot) begin
      new_a = '{group: step5(pos_a.group, mode_r), slot: pos_a.slot};
      new_b = '{group: step5(pos_b.group, mode_r), slot: pos_b.slot};
    end else begin
      new_a = '{group: pos_b.group, slot: pos_a.slot};
      new_b = '{group: pos_a.group, slot: pos_b.slot};
    end
    map_a = to_ascii(sq_at(square, new_a));
    map_b = to_ascii(sq_at(square, new_b));
  end

  assign out_fire      = pb_valid_r && out_tready;
  assign pb_free       = !pb_valid_r || (out_fire && pb_sel_r);
  assign move          = job_valid_r && pb_free;
  assign job_last_pair = !job_two_r || job_idx_r;
  assign in_tready     = !job_valid_r || (move && job_last_pair);
  assign in_fire       = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_letter_r <= '0;
      held_valid_r  <= 1'b0;
      prev_letter_r <= '0;
      prev_valid_r  <= 1'b0;
      job_valid_r   <= 1'b0;
      job_idx_r     <= 1'b0;
      pb_valid_r    <= 1'b0;
      pb_sel_r      <= 1'b0;
    end else begin
      if (in_fire) begin
        held_letter_r <= held_letter_nxt;
        held_valid_r  <= held_valid_nxt;
        prev_letter_r <= prev_letter_nxt;
        prev_valid_r  <= prev_valid_nxt;
      end

      // a byte that releases nothing leaves no job behind
      if (in_fire && np != 2'd0) begin
        job_valid_r <= 1'b1;
        job_idx_r   <= 1'b0;
      end else if (move && job_last_pair) begin
        job_valid_r <= 1'b0;
      end else if (move) begin
        job_idx_r <= 1'b1;
      end

      if (move) begin
        pb_valid_r <= 1'b1;
        pb_sel_r   <= 1'b0;
      end else if (out_fire) begin
        if (pb_sel_r)
          pb_valid_r <= 1'b0;
        else
          pb_sel_r <= 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire && np != 2'd0) begin
      job_a_r   <= pair_a;
      job_b_r   <= pair_b;
      job_two_r <= np[1];
      job_end_r <= in_tlast;
    end
    if (move) begin
      pb_a_r    <= map_a;
      pb_b_r    <= map_b;
      pb_last_r <= job_last_pair;
      pb_done_r <= job_last_pair && job_end_r;
    end
  end

  assign out_tvalid = pb_valid_r;
  assign out_tdata  = {1'b0, pb_sel_r ? pb_b_r : pb_a_r};
  assign out_tlast  = pb_sel_r && pb_last_r;
  assign out_tuser  = pb_sel_r && pb_done_r;

endmodule

// ===== rtl/pfc_checker.sv =====
// Port-level checks for the Playfair digraph cipher, bound to the top level.
// Uses pfc_pkg for the letter range.
module pfc_checker
  import pfc_pkg::*;
(
  input logic            clk,
  input logic            rst_n,
  input logic            out_tvalid,
  input logic            out_tready,
  input logic [7:0]      out_tdata,
  input logic            out_tlast,
  input logic            out_tuser
);

  // a stalled result transaction holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
      && $stable(out_tlast) && $stable(out_tuser))
    else $error("result transaction changed while stalled");

  // message end only ever marks the last letter of a run
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast)
    else $error("message_done without run_last");

  a_letter_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[7] == 1'b0 && out_tdata[6:0] >= LETTER_A
      && out_tdata[6:0] <= LETTER_MAX)
    else $error("cipher letter out of range");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result pending straight after reset");

endmodule

bind playfair_digraph_cipher_top pfc_checker u_pfc_checker (.*);

// ===== tb/playfair_letter_checker.sv =====
// Checker for the Playfair digraph cipher: follows the register writes and both
// streams, predicts each cipher letter and compares it with the output stream.
// Depends on pfc_pkg for the letter codes, ASCII constants and register indexes.
module playfair_letter_checker
  import pfc_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_we,
  input  logic [1:0]      cfg_addr,
  input  logic [CfgW-1:0] cfg_wdata,
  input  logic            in_tvalid,
  input  logic            in_tready,
  input  logic [7:0]      in_tdata,   // [7:0] text_byte
  input  logic            in_tlast,   // message_end
  input  logic            out_tvalid,
  input  logic            out_tready,
  input  logic [7:0]      out_tdata,  // [6:0] cipher_letter, [7] zero
  input  logic            out_tlast,  // run_last
  input  logic            out_tuser,  // [0] message_done
  output int              mismatch_total,
  output int              letters_due
);

  typedef struct packed {
    letter_t letter;
    logic    run_last;
    logic    msg_done;
  } cipher_out_t;

  cipher_out_t expected_letters[$];

  square_t square;
  logic    decrypt;
  code_t   held_code;
  logic    held_ok;
  code_t   last_code;
  logic    last_ok;
  int      errors = 0;

  // Lowest cell holding the code, cell 0 if the code is missing.
  function automatic int locate(code_t code);
    int where;
    where = -1;
    for (int p = 0; p < SqCells; p++)
      if (where < 0 && square[p*CodeW +: CodeW] == code) where = p;
    return (where < 0) ? 0 : where;
  endfunction

  task automatic emit_digraph(code_t a, code_t b);
    int pa, pb, ra, rb, ca, cb, na, nb, shift;
    cipher_out_t res;
    pa    = locate(a);
    pb    = locate(b);
    ra    = pa / 5;
    ca    = pa % 5;
    rb    = pb / 5;
    cb    = pb % 5;
    shift = decrypt ? 4 : 1;
    if (ra == rb) begin
      na = ra * 5 + (ca + shift) % 5;
      nb = rb * 5 + (cb + shift) % 5;
    end else if (ca == cb) begin
      na = ((ra + shift) % 5) * 5 + ca;
      nb = ((rb + shift) % 5) * 5 + cb;
    end else begin
      na = rb * 5 + ca;
      nb = ra * 5 + cb;
    end
    res = '{letter: LETTER_A + letter_t'(square[na*CodeW +: CodeW]), run_last: 1'b0,
            msg_done: 1'b0};
    expected_letters.push_back(res);
    res.letter = LETTER_A + letter_t'(square[nb*CodeW +: CodeW]);
    expected_letters.push_back(res);
  endtask

  task automatic take_letter(code_t c, inout int made);
    if (held_ok) begin
      held_ok = 1'b0;
      emit_digraph(held_code, c);
      made += 2;
    end else begin
      held_code = c;
      held_ok   = 1'b1;
    end
  endtask

  task automatic predict_byte(logic [7:0] b, logic closes);
    logic [7:0]  up;
    code_t       c;
    logic        is_alpha;
    int          made;
    cipher_out_t tail;
    up       = b;
    c        = '0;
    is_alpha = 1'b0;
    made     = 0;
    if (up >= ASCII_LC_A && up <= ASCII_LC_Z) up = up - CASE_OFFSET;
    if (up >= ASCII_UC_A && up <= ASCII_UC_Z) begin
      is_alpha = 1'b1;
      c = code_t'(up - ASCII_UC_A);
      if (c == CODE_J) c = CODE_I;
    end
    if (is_alpha) begin
      // filler only between two equal kept letters, never compared itself
      if (last_ok && last_code == c) take_letter((c == CODE_X) ? CODE_Q : CODE_X, made);
      take_letter(c, made);
      last_code = c;
      last_ok   = 1'b1;
    end
    if (closes) begin
      if (held_ok) take_letter(CODE_Z, made);
      held_ok = 1'b0;
      last_ok = 1'b0;
    end
    if (made > 0) begin
      tail = expected_letters.pop_back();
      tail.run_last = 1'b1;
      tail.msg_done = closes;
      expected_letters.push_back(tail);
    end
  endtask

  always @(posedge clk) begin : watch
    cipher_out_t want;
    if (!rst_n) begin
      square    = '0;
      decrypt   = 1'b0;
      held_code = '0;
      held_ok   = 1'b0;
      last_code = '0;
      last_ok   = 1'b0;
      expected_letters.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_SQUARE_LOW:  square[44:0]   = cfg_wdata;
          REG_SQUARE_MID:  square[89:45]  = cfg_wdata;
          REG_SQUARE_HIGH: square[124:90] = cfg_wdata[SqHighW-1:0];
          REG_CIPHER_MODE: decrypt        = cfg_wdata[0];
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        if (expected_letters.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("%0t: unexpected letter %c (last=%b done=%b), nothing pending",
                     $time, out_tdata[6:0], out_tlast, out_tuser);
        end else begin
          want = expected_letters.pop_front();
          if (out_tdata !== {1'b0, want.letter} || out_tlast !== want.run_last ||
              out_tuser !== want.msg_done) begin
            errors++;
            if (errors <= 10)
              $display("%0t: letter mismatch: expected %h last=%b done=%b, got %h last=%b done=%b",
                       $time, {1'b0, want.letter}, want.run_last, want.msg_done,
                       out_tdata, out_tlast, out_tuser);
          end
        end
      end
      if (in_tvalid && in_tready) predict_byte(in_tdata, in_tlast);
    end
    mismatch_total <= errors;
    letters_due    <= expected_letters.size();
  end

endmodule

// ===== tb/playfair_digraph_cipher_top_test.sv =====
// Testbench top for the Playfair digraph cipher: clock, reset, register
// settings, text stimulus with gaps and a long output hold-off, and the verdict.
// Depends on pfc_pkg, playfair_digraph_cipher_top and playfair_letter_checker.
module playfair_digraph_cipher_top_test;
  import pfc_pkg::*;

  localparam int WatchdogLimit = 3000;
  localparam int HoldOffCycles = 160;
  localparam int SettleCycles  = 12;

  typedef enum int {SQ_ALPHA, SQ_KEYED, SQ_RANDOM, SQ_ONES, SQ_ZEROS} square_kind_t;

  logic            clk        = 1'b0;
  logic            rst_n      = 1'b0;
  logic            cfg_we     = 1'b0;
  logic [1:0]      cfg_addr   = '0;
  logic [CfgW-1:0] cfg_wdata  = '0;
  logic            in_tvalid  = 1'b0;
  logic            in_tready;
  logic [7:0]      in_tdata   = '0;   // [7:0] text_byte
  logic            in_tlast   = 1'b0; // message_end
  logic            out_tvalid;
  logic            out_tready = 1'b0;
  logic [7:0]      out_tdata;         // [6:0] cipher_letter, [7] zero
  logic            out_tlast;         // run_last
  logic            out_tuser;         // [0] message_done

  int mismatch_total;
  int letters_due;
  int idle_cycles     = 0;
  bit gaps_on         = 1'b1;
  bit hold_off_req    = 1'b0;
  bit hold_off_served = 1'b0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  playfair_digraph_cipher_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  playfair_letter_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_addr       (cfg_addr),
    .cfg_wdata      (cfg_wdata),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tlast       (in_tlast),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tlast      (out_tlast),
    .out_tuser      (out_tuser),
    .mismatch_total (mismatch_total),
    .letters_due    (letters_due)
  );

  // Receiver: random back-pressure, plus one long hold-off on request.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_off_req && !hold_off_served) begin
        out_tready <= 1'b0;
        repeat (HoldOffCycles) @(posedge clk);
        hold_off_served = 1'b1;
      end else begin
        out_tready <= !gaps_on || ($urandom_range(99) >= 26);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  function automatic square_t make_square(square_kind_t kind);
    square_t sq;
    code_t   pool[SqCells];
    code_t   tmp;
    int      k, j;
    sq = '0;
    k  = 0;
    for (int c = 0; c < 26; c++) begin
      if (code_t'(c) != CODE_J) begin
        pool[k] = code_t'(c);
        k++;
      end
    end
    case (kind)
      SQ_ALPHA: begin
        for (int p = 0; p < SqCells; p++) sq[p*CodeW +: CodeW] = pool[p];
      end
      SQ_KEYED: begin
        for (int i = SqCells - 1; i > 0; i--) begin
          j       = $urandom_range(i);
          tmp     = pool[i];
          pool[i] = pool[j];
          pool[j] = tmp;
        end
        for (int p = 0; p < SqCells; p++) sq[p*CodeW +: CodeW] = pool[p];
      end
      SQ_RANDOM: begin
        // duplicates, missing letters and codes past Z all turn up here
        for (int p = 0; p < SqCells; p++) sq[p*CodeW +: CodeW] = code_t'($urandom_range(31));
      end
      SQ_ONES: sq = '1;
      default: sq = '0;
    endcase
    return sq;
  endfunction

  // Writes all four registers back to back; unused upper bits carry junk.
  task automatic load_setting(square_t sq, logic dec);
    logic [CfgW-1:0] junk;
    junk = CfgW'({$urandom(), $urandom()});
    cfg_we    <= 1'b1;
    cfg_addr  <= REG_SQUARE_LOW;
    cfg_wdata <= sq[44:0];
    @(posedge clk);
    cfg_addr  <= REG_SQUARE_MID;
    cfg_wdata <= sq[89:45];
    @(posedge clk);
    cfg_addr  <= REG_SQUARE_HIGH;
    cfg_wdata <= {junk[CfgW-1:SqHighW], sq[124:90]};
    @(posedge clk);
    cfg_addr  <= REG_CIPHER_MODE;
    cfg_wdata <= {junk[CfgW-1:1], dec};
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic send_byte(logic [7:0] b, logic closes);
    while (gaps_on && $urandom_range(99) < 26) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= closes;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic send_text(string s, logic closes);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], closes && (i == s.len() - 1));
  endtask

  // Drop valid, wait for every pending letter, then let the pipe empty.
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (letters_due != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_byte(logic [7:0] prior);
    int         r;
    logic [7:0] b;
    r = $urandom_range(99);
    if (r < 12)
      b = 8'($urandom_range(255));
    else if (r < 26)
      b = prior ^ (r[0] ? CASE_OFFSET : 8'h00);  // doubled letter
    else if (r < 36)
      b = (r % 3 == 0) ? 8'h78 : (r % 3 == 1) ? 8'h58 : 8'h6A;  // x, X, j
    else
      b = (r[0] ? ASCII_LC_A : ASCII_UC_A) + 8'($urandom_range(25));
    return b;
  endfunction

  task automatic random_phase(int count, bit with_hold);
    int         n, len;
    bit         hold_done;
    logic [7:0] b, prior;
    n         = 0;
    hold_done = 1'b0;
    prior     = ASCII_UC_A;
    while (n < count) begin
      if (with_hold && !hold_done && n >= 10) begin
        hold_off_req = 1'b1;
        hold_done    = 1'b1;
      end
      if ($urandom_range(19) == 0) begin
        // stray message end, usually with nothing to flush
        send_byte(8'($urandom_range(255)), 1'b1);
        n++;
      end else begin
        len = $urandom_range(1, 14);
        if (len > count - n) len = count - n;
        for (int i = 0; i < len; i++) begin
          b = pick_byte(prior);
          if ((b >= ASCII_UC_A && b <= ASCII_UC_Z) || (b >= ASCII_LC_A && b <= ASCII_LC_Z))
            prior = b;
          send_byte(b, i == len - 1);
          n++;
        end
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // registers still at their reset values: every cell holds A
    random_phase(15, 1'b0);
    settle();

    // ordered square without J, encrypt
    load_setting(make_square(SQ_ALPHA), 1'b0);
    send_text("aB", 1'b0);     // same row
    send_text("AF", 1'b0);     // same column
    send_text("ag", 1'b0);     // rectangle
    send_text("DE", 1'b0);     // row wraps
    send_text("AV", 1'b0);     // column wraps
    send_text("Jj", 1'b0);     // J folds to I, then doubled
    send_text("xX", 1'b0);     // doubled X takes Q
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h80, 1'b0);
    send_text("@[{", 1'b0);    // bytes just outside the letter ranges
    send_byte(8'h60, 1'b0);
    send_text("z", 1'b1);      // lone letter padded with Z
    send_byte(8'h2E, 1'b1);    // end with nothing held
    send_text("K", 1'b0);
    send_byte(8'h21, 1'b1);    // end on a non-letter while a letter is held
    send_text("LL", 1'b1);     // filler and pad from one byte: four letters
    settle();

    load_setting(make_square(SQ_KEYED), 1'b0);
    random_phase(75, 1'b0);
    settle();

    load_setting(make_square(SQ_KEYED), 1'b1);
    random_phase(75, 1'b1);
    settle();

    gaps_on = 1'b0;
    load_setting(make_square(SQ_ALPHA), 1'b1);
    random_phase(40, 1'b0);
    settle();
    gaps_on = 1'b1;

    load_setting(make_square(SQ_RANDOM), 1'b0);
    random_phase(70, 1'b0);
    settle();

    load_setting(make_square(SQ_ONES), 1'b1);
    random_phase(30, 1'b0);
    settle();

    load_setting(make_square(SQ_ZEROS), 1'b0);
    random_phase(30, 1'b0);
    settle();

    load_setting(make_square(SQ_RANDOM), 1'b1);
    random_phase(70, 1'b0);
    settle();

    if (mismatch_total == 0 && letters_due == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/pfc_pkg.sv
rtl/playfair_digraph_cipher_top.sv
rtl/pfc_checker.sv
tb/playfair_letter_checker.sv
tb/playfair_digraph_cipher_top_test.sv
